// File: rtl/bpsk_correlation_demodulator_macros.svh
// ----------------------------------------------------------------------------
// BPSK correlation demodulator assertion macros
// Concurrent assertion shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BPSK_CORRELATION_DEMODULATOR_MACROS_SVH
`define BPSK_CORRELATION_DEMODULATOR_MACROS_SVH

// same-cycle implication
`define BPSKCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPSKCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bpskcd_pkg.sv
// ----------------------------------------------------------------------------
// BPSK correlation demodulator package
// Shared widths, register codes, reset values, status type and sine builder.
// ----------------------------------------------------------------------------
package bpskcd_pkg;

  localparam int SINE_TABLE_DEPTH_DEF    = 1024;
  localparam int SAMPLE_WIDTH_DEF        = 16;
  localparam int MAX_SAMPLES_PER_BIT_DEF = 4096;

  localparam int PHASE_W    = 16;
  localparam int SPB_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SOFT_W     = 16;
  localparam int SOFT_FRAC  = 15;
  localparam int SINE_W     = 16;
  localparam int SINE_MAG_W = 15;

  localparam logic [SPB_W-1:0]   SPB_RESET        = SPB_W'(48);
  localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = PHASE_W'(5461);

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_BIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP      = CFG_IDX_W'(1);

  localparam longint unsigned PI_Q32  = 64'd13493037705;
  localparam longint unsigned Q30_ONE = 64'd1073741824;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // sine magnitude of a Q30 angle in [0, pi/2], scaled to 32767 and rounded
  function automatic logic [SINE_MAG_W-1:0] sine_mag(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned mag;
    longint          acc;
    int              n;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n < 14; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    s = 64'(acc);
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    mag = (64'd32767 * s + (Q30_ONE >> 1)) >> 30;
    return mag[SINE_MAG_W-1:0];
  endfunction

endpackage

// File: rtl/bpskcd_sine_rom.sv
// ----------------------------------------------------------------------------
// BPSK correlation demodulator sine reference
// Quarter-wave constant table with sign and mirror folding, registered read.
// ----------------------------------------------------------------------------
module bpskcd_sine_rom
  import bpskcd_pkg::*;
#(
  parameter int DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic signed [SINE_W-1:0] sine
);

  localparam int AW      = $clog2(DEPTH);
  localparam int QW      = AW - 1;
  localparam int QUARTER = DEPTH / 4;

  logic [SINE_MAG_W-1:0]    quarter_rom [QUARTER+1];
  logic [QW-1:0]            q_raw;
  logic [QW-1:0]            q_fold;
  logic signed [SINE_W-1:0] sine_nxt;
  logic signed [SINE_W-1:0] sine_r;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    localparam longint unsigned ANGLE =
      (64'(g) * PI_Q32 + 64'(DEPTH)) / 64'(2 * DEPTH);
    assign quarter_rom[g] = sine_mag(ANGLE);
  end

  always_comb begin
    q_raw = addr[AW-2:0];
    // mirror the second half of each half-wave: half minus q, mod half
    if (q_raw > QW'(QUARTER)) begin
      q_fold = ~q_raw + 1'b1;
    end else begin
      q_fold = q_raw;
    end
    if (addr[AW-1]) begin
      sine_nxt = -$signed({1'b0, quarter_rom[q_fold]});
    end else begin
      sine_nxt = $signed({1'b0, quarter_rom[q_fold]});
    end
  end

  always_ff @(posedge clk) begin
    sine_r <= sine_nxt;
  end

  assign sine = sine_r;

endmodule

// File: rtl/bpskcd_divider.sv
// ----------------------------------------------------------------------------
// BPSK correlation demodulator divider
// Restoring signed divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module bpskcd_divider
  import bpskcd_pkg::*;
#(
  parameter int DIVIDEND_W = 44,
  parameter int DIVISOR_W  = SPB_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic signed [DIVIDEND_W-1:0] quotient,
  output div_status_t                  status
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  always_comb begin
    rem_shift = {rem_r, quo_r[DIVIDEND_W-1]};
    fits      = rem_shift >= {1'b0, dsr_r};
    rem_sub   = rem_shift - {1'b0, dsr_r};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      neg_nxt  = dividend[DIVIDEND_W-1];
      quo_nxt  = dividend[DIVIDEND_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient    = neg_r ? $signed(~quo_r + 1'b1) : $signed(quo_r);
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: rtl/bpsk_correlation_demodulator.sv
// ----------------------------------------------------------------------------
// BPSK correlation demodulator
// Correlates samples with a sine reference per bit, emits soft and hard bit.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     in_sample, in_restart
// out      output     out_valid / out_stall   out_soft_value, out_hard_bit
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// A sample passes through table read, multiply and accumulate.
// A sample that closes a bit adds the restoring divider, one quotient bit per
// cycle over a dividend of SAMPLE_WIDTH + 16 + log2(MAX_SAMPLES_PER_BIT) bits
// (44 by default), then the output state hands the result over.
// Reset is synchronous; no clearing pass. cfg_ready is always high.
// A finished item waits in the output register while the next sample is
// taken; a bit end waits in the output state only if the previous item is still stalled.
// ----------------------------------------------------------------------------
`include "bpsk_correlation_demodulator_macros.svh"

module bpsk_correlation_demodulator
  import bpskcd_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH    = SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
  parameter int MAX_SAMPLES_PER_BIT = MAX_SAMPLES_PER_BIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SOFT_W-1:0]       out_soft_value,
  output logic                           out_hard_bit,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata
);

  localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W  = SAMPLE_WIDTH + SINE_W;
  localparam int SUM_W   = SAMPLE_WIDTH + SINE_W + $clog2(MAX_SAMPLES_PER_BIT);

  localparam logic signed [SUM_W-1:0] SOFT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SOFT_MIN = SUM_W'(-32768);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [SPB_W-1:0]           spb_r, spb_nxt;
  logic [PHASE_W-1:0]         step_r, step_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SPB_W-1:0]           count_r, count_nxt;
  logic [PHASE_W-1:0]         phase_r, phase_nxt;
  logic                       hard_r, hard_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SOFT_W-1:0]   out_soft_r, out_soft_nxt;
  logic                       out_hard_r, out_hard_nxt;

  logic [PHASE_W-1:0]         phase_use;
  logic [SINE_AW-1:0]         rom_addr;
  logic signed [SINE_W-1:0]   rom_sine;
  logic [SPB_W-1:0]           bit_len;
  logic                       bit_end;
  logic signed [SUM_W-1:0]    sum_acc;
  logic                       div_start;
  logic signed [SUM_W-1:0]    div_quotient;
  div_status_t                div_status;
  logic signed [SUM_W-1:0]    soft_wide;
  logic signed [SOFT_W-1:0]   soft_sat;

  bpskcd_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .sine (rom_sine)
  );

  bpskcd_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (SPB_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_acc),
    .divisor  (bit_len),
    .quotient (div_quotient),
    .status   (div_status)
  );

  always_comb begin
    phase_use = in_restart ? '0 : phase_r;
    rom_addr  = phase_use[PHASE_W-1 -: SINE_AW];

    if (spb_r == '0) begin
      bit_len = SPB_W'(1);
    end else if (32'(spb_r) > MAX_SAMPLES_PER_BIT) begin
      bit_len = SPB_W'(MAX_SAMPLES_PER_BIT);
    end else begin
      bit_len = spb_r;
    end
    bit_end = count_r >= bit_len;
    sum_acc = sum_r + SUM_W'(prod_r);

    soft_wide = div_quotient >>> SOFT_FRAC;
    if (soft_wide > SOFT_MAX) begin
      soft_sat = SOFT_W'(SOFT_MAX);
    end else if (soft_wide < SOFT_MIN) begin
      soft_sat = SOFT_W'(SOFT_MIN);
    end else begin
      soft_sat = soft_wide[SOFT_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    spb_nxt       = spb_r;
    step_nxt      = step_r;
    sample_nxt    = sample_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    hard_nxt      = hard_r;
    out_valid_nxt = out_valid_r;
    out_soft_nxt  = out_soft_r;
    out_hard_nxt  = out_hard_r;
    div_start     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLES_PER_BIT: spb_nxt = cfg_wdata[SPB_W-1:0];
        CFG_PHASE_STEP:      step_nxt = cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          sum_nxt    = in_restart ? '0 : sum_r;
          count_nxt  = (in_restart ? '0 : count_r) + SPB_W'(1);
          phase_nxt  = phase_use + step_r;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = sample_r * rom_sine;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (bit_end) begin
          // close the bit: start the divide, drop the running state
          hard_nxt  = !sum_acc[SUM_W-1] && (sum_acc != '0);
          div_start = 1'b1;
          sum_nxt   = '0;
          count_nxt = '0;
          phase_nxt = '0;
          state_nxt = ST_DIV;
        end else begin
          sum_nxt   = sum_acc;
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_soft_nxt  = soft_sat;
          out_hard_nxt  = hard_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spb_r       <= SPB_RESET;
      step_r      <= PHASE_STEP_RESET;
      sum_r       <= '0;
      count_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spb_r       <= spb_nxt;
      step_r      <= step_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    prod_r     <= prod_nxt;
    hard_r     <= hard_nxt;
    out_soft_r <= out_soft_nxt;
    out_hard_r <= out_hard_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_soft_value = out_soft_r;
  assign out_hard_bit   = out_hard_r;

  `BPSKCD_ASSERT_IMP(a_div_busy_in_div, div_status.busy, state_r == ST_DIV, "divider busy outside divide state")
  `BPSKCD_ASSERT_NXT(a_accept_to_mul, in_valid && !in_stall, state_r == ST_MUL, "accepted item did not enter multiply")
  `BPSKCD_ASSERT_IMP(a_out_load_from_out, !out_valid_r ##1 out_valid_r, $past(state_r == ST_OUT), "result loaded outside output state")
  `BPSKCD_ASSERT_NXT(a_bit_end_clears, state_r == ST_ACC && bit_end, sum_r == '0 && count_r == '0 && phase_r == '0, "bit end did not clear running state")

endmodule
